>>> hdl/pole_zero_response_eval_top_defines.svh
// ----------------------------------------------------------------------------
// pole_zero_response_eval_top_defines.svh
// Assertion macros shared by the pole-zero response evaluator.
// ----------------------------------------------------------------------------
`ifndef POLE_ZERO_RESPONSE_EVAL_TOP_DEFINES_SVH
`define POLE_ZERO_RESPONSE_EVAL_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted
`define PZR_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("pzr assertion failed");
// Clocked check that also holds during reset
`define PZR_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("pzr assertion failed");
`else
`define PZR_ASSERT(lbl, clk, rstn, prop)
`define PZR_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> hdl/pzr_pkg.sv
// ----------------------------------------------------------------------------
// pzr_pkg
// Types, codes and saturation helper for the pole-zero response evaluator.
// ----------------------------------------------------------------------------
package pzr_pkg;

	// input item kinds
	localparam logic [1:0] KIND_LOAD_ZERO = 2'd0;
	localparam logic [1:0] KIND_LOAD_POLE = 2'd1;
	localparam logic [1:0] KIND_EVAL      = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_GAIN       = 2'd0;
	localparam logic [1:0] REG_ZERO_COUNT = 2'd1;
	localparam logic [1:0] REG_POLE_COUNT = 2'd2;

	localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

	// one cell: one zero and one pole, 32-bit re/im each
	typedef struct packed {
		logic signed [31:0] zre;
		logic signed [31:0] zim;
		logic signed [31:0] pre;
		logic signed [31:0] pim;
	} root_pair_t;

	// table write request broadcast to all cells
	typedef struct packed {
		logic               zero_we;
		logic               pole_we;
		logic [4:0]         slot;
		logic signed [31:0] re;
		logic signed [31:0] im;
	} load_t;

	// commands into the evaluation engine
	typedef struct packed {
		logic               start;
		logic signed [31:0] omega;
		logic signed [31:0] gain;
		logic [4:0]         zero_count;
		logic [4:0]         pole_count;
		logic               out_free;
	} eng_cmd_t;

	// status out of the evaluation engine
	typedef struct packed {
		logic               idle;
		logic               shift;
		logic               done;
		logic signed [31:0] res_re;
		logic signed [31:0] res_im;
		logic               ov;
		logic               dz;
	} eng_stat_t;

	typedef struct packed {
		logic signed [31:0] v;
		logic               ov;
	} sat_t;

	// saturate a wide signed value to 32 bits
	function automatic sat_t sat32(input logic signed [65:0] x);
		sat_t r;
		if (x > 66'(VAL_MAX)) begin
			r.v  = VAL_MAX;
			r.ov = 1'b1;
		end else if (x < 66'(VAL_MIN)) begin
			r.v  = VAL_MIN;
			r.ov = 1'b1;
		end else begin
			r.v  = x[31:0];
			r.ov = 1'b0;
		end
		return r;
	endfunction

endpackage

>>> hdl/pzr_if.sv
// ----------------------------------------------------------------------------
// pzr_if
// Valid/ready channel interfaces: input items, results, register writes.
// ----------------------------------------------------------------------------
interface pzr_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [4:0]         slot;
	logic signed [31:0] coef_re;
	logic signed [31:0] coef_im;
	logic signed [31:0] omega;
	modport source (output valid, kind, slot, coef_re, coef_im, omega, input ready);
	modport sink   (input valid, kind, slot, coef_re, coef_im, omega, output ready);
endinterface

interface pzr_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] resp_re;
	logic signed [31:0] resp_im;
	logic               overflow;
	logic               div_zero;
	modport source (output valid, resp_re, resp_im, overflow, div_zero, input ready);
	modport sink   (input valid, resp_re, resp_im, overflow, div_zero, output ready);
endinterface

interface pzr_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/pole_zero_response_eval_top.sv
// ----------------------------------------------------------------------------
// pole_zero_response_eval_top
// Pole-zero frequency response evaluator, signed fixed point.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake     | payload
//  in_ch    | in        | valid/ready   | kind, slot, coef_re, coef_im, omega
//  out_ch   | out       | valid/ready   | resp_re, resp_im, overflow, div_zero
//  cfg_ch   | in        | valid/ready   | index, data (always ready)
//
//  An evaluation walks all MAX_ROOTS cells of the row: every index forms its
//  zero and pole factors, each used zero adds a complex multiply, and each
//  used pole adds a denominator and a division in the bit-serial dividers;
//  the gain multiply and the hand-off follow the last index.
//  Reset clears control and configuration; table contents are undefined.
//  A finished result waits in the output register while the next item is
//  accepted; the next evaluation result waits in the engine until it drains.
// ----------------------------------------------------------------------------
`include "pole_zero_response_eval_top_defines.svh"

module pole_zero_response_eval_top import pzr_pkg::*; #(
	parameter int MAX_ROOTS = 30,
	parameter int FRAC_BITS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	pzr_in_if.sink    in_ch,
	pzr_out_if.source out_ch,
	pzr_cfg_if.sink   cfg_ch
);

	logic signed [31:0] gain_q;
	logic [4:0]         zero_count_q, pole_count_q;
	logic               in_xfer, out_valid_q, out_free, out_load;
	logic signed [31:0] resp_re_q, resp_im_q;
	logic               overflow_q, div_zero_q;
	logic               resp_zero;
	load_t              ld;
	eng_cmd_t           cmd;
	eng_stat_t          stat;
	root_pair_t         pair [MAX_ROOTS];

	// configuration registers
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q       <= 32'(64'd1 << FRAC_BITS);
			zero_count_q <= '0;
			pole_count_q <= '0;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_GAIN:       gain_q       <= cfg_ch.data;
				REG_ZERO_COUNT: zero_count_q <= cfg_ch.data[4:0];
				REG_POLE_COUNT: pole_count_q <= cfg_ch.data[4:0];
				default: ;
			endcase
		end
	end

	// input side
	assign in_ch.ready = stat.idle;
	assign in_xfer     = in_ch.valid && in_ch.ready;

	assign ld.zero_we = in_xfer && (in_ch.kind == KIND_LOAD_ZERO);
	assign ld.pole_we = in_xfer && (in_ch.kind == KIND_LOAD_POLE);
	assign ld.slot    = in_ch.slot;
	assign ld.re      = in_ch.coef_re;
	assign ld.im      = in_ch.coef_im;

	// row of table cells, rotating toward cell 0
	for (genvar k = 0; k < MAX_ROOTS; k++) begin : g_cell
		localparam int NXT = (k + 1) % MAX_ROOTS;
		pzr_cell #(.IDX(k)) u_cell (
			.clk(clk), .shift(stat.shift), .ld(ld), .nxt(pair[NXT]), .cur(pair[k])
		);
	end

	// evaluation engine
	assign cmd.start      = in_xfer && (in_ch.kind == KIND_EVAL);
	assign cmd.omega      = in_ch.omega;
	assign cmd.gain       = gain_q;
	assign cmd.zero_count = zero_count_q;
	assign cmd.pole_count = pole_count_q;
	assign cmd.out_free   = out_free;

	pzr_engine #(.MAX_ROOTS(MAX_ROOTS), .FRAC_BITS(FRAC_BITS)) u_engine (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .head(pair[0]), .stat(stat)
	);

	// output register
	assign out_free = !out_valid_q || out_ch.ready;
	assign out_load = stat.done && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= out_load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			resp_re_q  <= stat.res_re;
			resp_im_q  <= stat.res_im;
			overflow_q <= stat.ov;
			div_zero_q <= stat.dz;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.resp_re  = resp_re_q;
	assign out_ch.resp_im  = resp_im_q;
	assign out_ch.overflow = overflow_q;
	assign out_ch.div_zero = div_zero_q;

	// checks
	assign resp_zero = (out_ch.resp_re == '0) && (out_ch.resp_im == '0);

	`PZR_ASSERT(a_eval_busy, clk, arst_n, cmd.start |=> !in_ch.ready)
	`PZR_ASSERT(a_load_from_engine, clk, arst_n, out_load |-> !stat.idle && !stat.shift)
	`PZR_ASSERT(a_divzero_result, clk, arst_n, (out_ch.valid && out_ch.div_zero) |-> resp_zero)
	`PZR_ASSERT_ALWAYS(a_no_shift_idle, clk, !(stat.shift && stat.idle))

endmodule

>>> hdl/pzr_cell.sv
// ----------------------------------------------------------------------------
// pzr_cell
// One table cell: holds zero and pole of one index, rotates to its neighbor.
// ----------------------------------------------------------------------------
module pzr_cell import pzr_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic       clk,
	input  logic       shift,
	input  load_t      ld,
	input  root_pair_t nxt,
	output root_pair_t cur
);

	root_pair_t pair_q;
	logic       hit;

	assign hit = ({2'b00, ld.slot} == 7'(IDX));

	// rotate during evaluation, load while idle
	always_ff @(posedge clk) begin
		if (shift) begin
			pair_q <= nxt;
		end else begin
			if (ld.zero_we && hit) begin
				pair_q.zre <= ld.re;
				pair_q.zim <= ld.im;
			end
			if (ld.pole_we && hit) begin
				pair_q.pre <= ld.re;
				pair_q.pim <= ld.im;
			end
		end
	end

	assign cur = pair_q;

endmodule

>>> hdl/pzr_div.sv
// ----------------------------------------------------------------------------
// pzr_div
// Restoring divider, one bit a cycle: num * 2^FRAC / den, toward zero, sat.
// ----------------------------------------------------------------------------
module pzr_div import pzr_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [65:0] num,
	input  logic [63:0]        den,
	output logic               done,
	output logic signed [31:0] q,
	output logic               ov
);

	localparam int DW = 65 + FRAC_BITS;
	localparam int CW = $clog2(DW + 1);

	logic          busy_q, done_q, neg_q, big_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] dvd_q;
	logic [63:0]   rem_q, den_q;
	logic [32:0]   quo_q;
	logic [65:0]   mag;
	logic [64:0]   r2, diff;
	logic          ge;

	assign mag  = num[65] ? 66'(-num) : 66'(num);
	assign r2   = {rem_q, dvd_q[DW-1]};
	assign diff = r2 - {1'b0, den_q};
	assign ge   = (r2 >= {1'b0, den_q});

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[65];
			dvd_q <= {mag[64:0], {FRAC_BITS{1'b0}}};
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
			big_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[63:0] : r2[63:0];
			big_q <= big_q | quo_q[32];
			quo_q <= {quo_q[31:0], ge};
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
		end
	end

	// sign and saturation
	always_comb begin
		ov = 1'b0;
		q  = '0;
		if (neg_q) begin
			if (big_q || (quo_q > 33'h0_8000_0000)) begin
				ov = 1'b1;
				q  = VAL_MIN;
			end else begin
				q = 32'(-quo_q);
			end
		end else begin
			if (big_q || (quo_q > 33'h0_7FFF_FFFF)) begin
				ov = 1'b1;
				q  = VAL_MAX;
			end else begin
				q = quo_q[31:0];
			end
		end
	end

	assign done = done_q;

endmodule

>>> hdl/pzr_engine.sv
// ----------------------------------------------------------------------------
// pzr_engine
// Sequencer with one shared multiplier and two dividers; walks the cell row.
// ----------------------------------------------------------------------------
module pzr_engine import pzr_pkg::*; #(
	parameter int MAX_ROOTS = 30,
	parameter int FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  eng_cmd_t   cmd,
	input  root_pair_t head,
	output eng_stat_t  stat
);

	localparam int IW = (MAX_ROOTS > 1) ? $clog2(MAX_ROOTS) : 1;

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_ZFAC = 11'b000_0000_0010,
		S_MUL  = 11'b000_0000_0100,
		S_PFAC = 11'b000_0000_1000,
		S_DEN  = 11'b000_0001_0000,
		S_DIV  = 11'b000_0010_0000,
		S_NEXT = 11'b000_0100_0000,
		S_GAIN = 11'b000_1000_0000,
		S_DONE = 11'b001_0000_0000,
		S_SPR0 = 11'b010_0000_0000,
		S_SPR1 = 11'b100_0000_0000
	} state_t;

	state_t             state_q;
	logic [2:0]         ph_q;
	logic [IW-1:0]      idx_q;
	logic signed [31:0] acc_re_q, acc_im_q, f_re_q, f_im_q, w_q;
	logic signed [31:0] res_re_q, res_im_q;
	logic               ov_q, dz_q;
	logic signed [63:0] prod_s1;
	logic signed [65:0] t_re_q, t_im_q, px;
	logic [63:0]        den_q;
	logic signed [31:0] mul_a, mul_b;
	logic               zero_use, pole_use, div_start;
	logic               dre_done, dim_done, dre_ov, dim_ov;
	logic signed [31:0] dre_q, dim_q;
	logic signed [31:0] fac_re_src, fac_im_src;
	sat_t               fre_s, fim_s, sre_s, sim_s;

	assign zero_use = (8'(idx_q) < 8'(cmd.zero_count));
	assign pole_use = (8'(idx_q) < 8'(cmd.pole_count));
	assign px       = {{2{prod_s1[63]}}, prod_s1};

	// factor jw - root for the root at the head cell
	assign fac_re_src = state_q[1] ? head.zre : head.pre;
	assign fac_im_src = state_q[1] ? head.zim : head.pim;
	assign fre_s = sat32(-66'(fac_re_src));
	assign fim_s = sat32(66'(w_q) - 66'(fac_im_src));

	// scaled products back to 32 bits
	assign sre_s = sat32(t_re_q >>> FRAC_BITS);
	assign sim_s = sat32(t_im_q >>> FRAC_BITS);

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = f_re_q;
		mul_b = f_re_q;
		case (state_q)
			S_MUL: begin
				case (ph_q)
					3'd0: begin mul_a = acc_re_q; mul_b = f_re_q; end
					3'd1: begin mul_a = acc_im_q; mul_b = f_im_q; end
					3'd2: begin mul_a = acc_re_q; mul_b = f_im_q; end
					default: begin mul_a = acc_im_q; mul_b = f_re_q; end
				endcase
			end
			S_DEN: begin
				case (ph_q)
					3'd0: begin mul_a = f_re_q; mul_b = f_re_q; end
					3'd1: begin mul_a = f_im_q; mul_b = f_im_q; end
					3'd2: begin mul_a = acc_re_q; mul_b = f_re_q; end
					3'd3: begin mul_a = acc_im_q; mul_b = f_im_q; end
					3'd4: begin mul_a = acc_im_q; mul_b = f_re_q; end
					default: begin mul_a = acc_re_q; mul_b = f_im_q; end
				endcase
			end
			S_GAIN: begin
				mul_a = (ph_q == 3'd0) ? acc_re_q : acc_im_q;
				mul_b = cmd.gain;
			end
			default: begin
				mul_a = f_re_q;
				mul_b = f_re_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	assign div_start = (state_q == S_DEN) && (ph_q == 3'd7) && (den_q != '0);

	pzr_div #(.FRAC_BITS(FRAC_BITS)) u_div_re (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(t_re_q), .den(den_q),
		.done(dre_done), .q(dre_q), .ov(dre_ov)
	);

	pzr_div #(.FRAC_BITS(FRAC_BITS)) u_div_im (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(t_im_q), .den(den_q),
		.done(dim_done), .q(dim_q), .ov(dim_ov)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q    <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						state_q <= S_ZFAC;
						idx_q   <= '0;
					end
				end
				S_ZFAC: begin
					ph_q    <= '0;
					state_q <= zero_use ? S_MUL : S_PFAC;
				end
				S_MUL: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 3'd5) begin
						state_q <= S_PFAC;
					end
				end
				S_PFAC: begin
					ph_q    <= '0;
					state_q <= pole_use ? S_DEN : S_NEXT;
				end
				S_DEN: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 3'd7) begin
						state_q <= (den_q == '0) ? S_NEXT : S_DIV;
					end
				end
				S_DIV: begin
					if (dre_done) begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					ph_q  <= '0;
					idx_q <= idx_q + 1'b1;
					if (idx_q == IW'(MAX_ROOTS - 1)) begin
						state_q <= S_GAIN;
					end else begin
						state_q <= S_ZFAC;
					end
				end
				S_GAIN: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 3'd3) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (cmd.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				acc_re_q <= 32'(64'd1 << FRAC_BITS);
				acc_im_q <= '0;
				ov_q     <= 1'b0;
				dz_q     <= 1'b0;
				w_q      <= cmd.omega;
			end
			S_ZFAC, S_PFAC: begin
				f_re_q <= fre_s.v;
				f_im_q <= fim_s.v;
				if ((state_q == S_ZFAC && zero_use) || (state_q == S_PFAC && pole_use)) begin
					ov_q <= ov_q | fre_s.ov | fim_s.ov;
				end
			end
			S_MUL: begin
				case (ph_q)
					3'd1: t_re_q <= px;
					3'd2: t_re_q <= t_re_q - px;
					3'd3: t_im_q <= px;
					3'd4: t_im_q <= t_im_q + px;
					3'd5: begin
						acc_re_q <= sre_s.v;
						acc_im_q <= sim_s.v;
						ov_q     <= ov_q | sre_s.ov | sim_s.ov;
					end
					default: ;
				endcase
			end
			S_DEN: begin
				case (ph_q)
					3'd1: den_q  <= 64'(prod_s1);
					3'd2: den_q  <= den_q + 64'(prod_s1);
					3'd3: t_re_q <= px;
					3'd4: t_re_q <= t_re_q + px;
					3'd5: t_im_q <= px;
					3'd6: t_im_q <= t_im_q - px;
					3'd7: begin
						if (den_q == '0) begin
							acc_re_q <= '0;
							acc_im_q <= '0;
							dz_q     <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			S_DIV: begin
				if (dre_done && dim_done) begin
					acc_re_q <= dre_q;
					acc_im_q <= dim_q;
					ov_q     <= ov_q | dre_ov | dim_ov;
				end
			end
			S_GAIN: begin
				case (ph_q)
					3'd1: t_re_q <= px;
					3'd2: t_im_q <= px;
					3'd3: begin
						res_re_q <= sre_s.v;
						res_im_q <= sim_s.v;
						ov_q     <= ov_q | sre_s.ov | sim_s.ov;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign stat.idle   = (state_q == S_IDLE);
	assign stat.shift  = (state_q == S_NEXT);
	assign stat.done   = (state_q == S_DONE);
	assign stat.res_re = res_re_q;
	assign stat.res_im = res_im_q;
	assign stat.ov     = ov_q;
	assign stat.dz     = dz_q;

endmodule
